// ----- rtl/telnet_iac_input_filter_defines.svh -----
// Assertion macros used by the checker file of the telnet IAC filter.
`ifndef TELNET_IAC_INPUT_FILTER_DEFINES_SVH
`define TELNET_IAC_INPUT_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TIAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live during reset.
`define TIAC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tiac_pkg.sv -----
// Types, constants and helpers shared by the telnet IAC filter modules.
package tiac_pkg;

    localparam logic [7:0] IAC_BYTE   = 8'd255;
    localparam logic [7:0] AYT_BYTE   = 8'd246;
    localparam logic [7:0] WILL_BYTE  = 8'd251;
    localparam logic [7:0] WONT_BYTE  = 8'd252;
    localparam logic [7:0] DO_BYTE    = 8'd253;
    localparam logic [7:0] ASCII_TOP  = 8'd127;
    localparam logic [7:0] ESCAPED_FF = 8'hFF;
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] VERB_STEP  = DO_BYTE - WILL_BYTE;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_INTR  = 2'd2;

    localparam logic [8:0] INTR_CHAR_RESET = 9'd3;

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_IAC  = 2'd1,
        PH_CMD  = 2'd2
    } t_phase;

    // What the back end has to emit for one accepted word.
    typedef enum logic [1:0] {
        OP_DATA = 2'd0,  // one data byte
        OP_INTR = 2'd1,  // one keyboard interrupt event
        OP_AYT  = 2'd2,  // reply IAC AYT
        OP_NEG  = 2'd3   // reply IAC verb 0
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    function automatic logic [7:0] reply_verb(input logic [7:0] verb);
        logic [7:0] result;
        if (verb < DO_BYTE) begin
            result = verb + VERB_STEP;
        end else begin
            result = verb - VERB_STEP;
        end
        return result;
    endfunction

endpackage

// ----- rtl/tiac_in_if.sv -----
// Receive channel: one telnet byte or a new-connection marker per word.
interface tiac_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;
    logic       logged_in;

    modport source (output valid, action, rx_byte, logged_in, input ready);
    modport sink (input valid, action, rx_byte, logged_in, output ready);
endinterface

// ----- rtl/tiac_out_if.sv -----
// Result channel: data bytes, reply bytes and interrupt events.
interface tiac_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_kind, out_byte, last, input ready);
    modport sink (input valid, out_kind, out_byte, last, output ready);
endinterface

// ----- rtl/tiac_cfg_if.sv -----
// Configuration write channel for the interrupt character register.
interface tiac_cfg_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] interrupt_char;

    modport source (output valid, interrupt_char, input ready);
    modport sink (input valid, interrupt_char, output ready);
endinterface

// ----- rtl/tiac_queue.sv -----
// Small command queue between the parser front end and the emitter back end.
module tiac_queue
    import tiac_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_push_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd           r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic [CW-1:0]  n_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/tiac_front.sv -----
// Front end: accepts received words, tracks the IAC parse phase and queues commands.
module tiac_front
    import tiac_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tiac_in_if.sink  i_in,
    tiac_cfg_if.sink i_cfg,
    input  logic  i_full,
    output logic  o_push,
    output t_cmd  o_cmd
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       r_binary;
    logic       n_binary;
    logic [8:0] r_intr_char;

    logic       w_accept;
    logic       w_match;
    logic       w_drop;
    logic [7:0] w_ch;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_ch        = i_in.rx_byte;

    // A negative interrupt character switches detection off.
    assign w_match = !r_intr_char[8] && (r_intr_char[7:0] == w_ch);
    assign w_drop  = (w_ch > ASCII_TOP) || (w_ch == 8'd0) || (i_in.logged_in && w_match);

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_binary = r_binary;
        if (w_accept) begin
            if (i_in.action) begin
                n_phase  = PH_DATA;
                n_held   = 8'd0;
                n_binary = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_IAC: begin
                        if (w_ch == IAC_BYTE || w_ch == AYT_BYTE) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_held  = w_ch;
                            n_phase = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        if (w_ch == OPT_BINARY) begin
                            if (r_held == WILL_BYTE) begin
                                n_binary = 1'b1;
                            end
                            if (r_held == WONT_BYTE) begin
                                n_binary = 1'b0;
                            end
                        end
                        n_phase = PH_DATA;
                    end
                    default: begin
                        n_phase = (w_ch == IAC_BYTE) ? PH_IAC : PH_DATA;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '{op: OP_DATA, value: w_ch};
        if (w_accept && !i_in.action) begin
            unique case (r_phase)
                PH_IAC: begin
                    if (w_ch == IAC_BYTE) begin
                        o_push = 1'b1;
                        o_cmd  = '{op: OP_DATA, value: ESCAPED_FF};
                    end else if (w_ch == AYT_BYTE) begin
                        o_push = 1'b1;
                        o_cmd  = '{op: OP_AYT, value: AYT_BYTE};
                    end
                end
                PH_CMD: begin
                    if (w_ch == OPT_BINARY) begin
                        o_push = 1'b1;
                        o_cmd  = '{op: OP_NEG, value: reply_verb(r_held)};
                    end
                end
                default: begin
                    if (w_ch != IAC_BYTE) begin
                        if (r_binary || !w_drop) begin
                            o_push = 1'b1;
                        end else if (w_match) begin
                            o_push = 1'b1;
                            o_cmd  = '{op: OP_INTR, value: 8'd0};
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DATA;
            r_held      <= 8'd0;
            r_binary    <= 1'b0;
            r_intr_char <= INTR_CHAR_RESET;
        end else begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_binary <= n_binary;
            if (i_cfg.valid && i_cfg.ready) begin
                r_intr_char <= i_cfg.interrupt_char;
            end
        end
    end

endmodule

// ----- rtl/tiac_back.sv -----
// Back end: takes queued commands and emits their result words one per cycle while the output is ready.
module tiac_back
    import tiac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_head,
    output logic    o_pop,
    tiac_out_if.source o_out
);

    logic       r_busy;
    logic [1:0] r_idx;
    t_cmd       r_cur;

    logic       w_last;
    logic       w_fire;
    logic       w_load;

    always_comb begin
        unique case (r_cur.op)
            OP_AYT:  w_last = (r_idx == 2'd1);
            OP_NEG:  w_last = (r_idx == 2'd2);
            default: w_last = 1'b1;
        endcase
    end

    assign w_fire = r_busy && o_out.ready;
    // The next command loads as the last word of the current one leaves.
    assign w_load = !r_busy || (w_fire && w_last);
    assign o_pop  = w_load && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_load) begin
            r_busy <= i_head.valid;
            r_idx  <= 2'd0;
        end else if (w_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_head.cmd;
        end
    end

    assign o_out.valid = r_busy;
    assign o_out.last  = w_last;

    always_comb begin
        unique case (r_cur.op)
            OP_DATA: begin
                o_out.out_kind = KIND_DATA;
                o_out.out_byte = r_cur.value;
            end
            OP_INTR: begin
                o_out.out_kind = KIND_INTR;
                o_out.out_byte = 8'd0;
            end
            OP_AYT: begin
                o_out.out_kind = KIND_REPLY;
                o_out.out_byte = (r_idx == 2'd0) ? IAC_BYTE : AYT_BYTE;
            end
            default: begin
                o_out.out_kind = KIND_REPLY;
                if (r_idx == 2'd0) begin
                    o_out.out_byte = IAC_BYTE;
                end else if (r_idx == 2'd1) begin
                    o_out.out_byte = r_cur.value;
                end else begin
                    o_out.out_byte = OPT_BINARY;
                end
            end
        endcase
    end

endmodule

// ----- rtl/telnet_iac_input_filter.sv -----
// Telnet receive filter: one received byte is taken per cycle whenever the command queue has
// room. The front end updates the IAC parse phase in the cycle it accepts a byte and queues
// at most one command; the back end emits one result word per cycle while the output is ready,
// so a byte with no or one result sustains one byte per cycle, an AYT echo holds the back end
// for two words and a binary option reply for three. A queue of QUEUE_DEPTH commands lets the
// input keep flowing while replies serialise. Results pass through queue and back end registers.
module telnet_iac_input_filter
    import tiac_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tiac_in_if.sink    i_in,
    tiac_cfg_if.sink   i_cfg,
    tiac_out_if.source o_out
);

    logic    w_full;
    logic    w_push;
    t_cmd    w_cmd;
    logic    w_pop;
    t_q_head w_head;

    tiac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    tiac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    tiac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/tiac_checker.sv -----
// Port-level checks on the telnet IAC filter, bound to its top level.
`include "telnet_iac_input_filter_defines.svh"

module tiac_checker
    import tiac_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    `TIAC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid, "result word valid after reset")
    `TIAC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_byte) && $stable(i_out_last), "stalled result word changed")
    `TIAC_ASSERT_NOW(a_intr_single, i_clk, i_rst_n, i_out_valid && i_out_kind == KIND_INTR, i_out_byte == 8'd0 && i_out_last, "interrupt event not a lone zero word")
    `TIAC_ASSERT_NOW(a_data_single, i_clk, i_rst_n, i_out_valid && i_out_kind == KIND_DATA, i_out_last, "data byte not the last word of its byte")
    `TIAC_ASSERT_NEXT(a_reply_follows, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_kind == KIND_REPLY && !i_out_last, i_out_valid && i_out_kind == KIND_REPLY, "reply sequence broken")

endmodule

bind telnet_iac_input_filter tiac_checker u_tiac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.out_kind),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
